>>> rtl/mjtp_pkg.sv
// Shared widths, register indexes and helpers for the multi-joint trapezoid
// profile core. No dependencies; used by the channel interfaces and the core.
package mjtp_pkg;

   localparam int POS_W      = 32;  // Q16.16 positions and velocities
   localparam int JOINT_W    = 3;   // joint number on the channels
   localparam int PEAK_W     = 16;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // datapath widths, sized for acceleration spans of up to 16 ticks
   localparam int VT_W  = 48;      // peak velocity times tick count
   localparam int R_W   = 20;      // remaining distance in the deceleration phase
   localparam int BS_W  = 40;      // position multiplicand
   localparam int BV_W  = 20;      // velocity multiplicand
   localparam int C_W   = 53;      // divisor
   localparam int Q_W   = 34;      // quotient
   localparam int PP_W  = 52;      // partial product
   localparam int NUM_W = 73;      // rounded dividend

   localparam logic [CSR_IDX_W-1:0] REG_PEAK_VELOCITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_JOINTS_IN_USE = 2'd1;

   localparam logic [PEAK_W-1:0]  PEAK_VELOCITY_RST = 16'd655;
   localparam logic [COUNT_W-1:0] JOINTS_IN_USE_RST = 4'd8;

   typedef enum logic [3:0] {
      PH_ACCEL  = 4'b0001,
      PH_CRUISE = 4'b0010,
      PH_DECEL  = 4'b0100,
      PH_HOLD   = 4'b1000
   } phase_type;

   function automatic logic [POS_W-1:0] sat32(input logic signed [35:0] v);
      logic [POS_W-1:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -36'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/mjtp_channels.sv
// Valid/ready channel interfaces of the multi-joint trapezoid profile core.
// Depends on mjtp_pkg for field widths.
interface mjtp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [mjtp_pkg::JOINT_W-1:0]        joint_index;
   logic signed [mjtp_pkg::POS_W-1:0]   start_position;
   logic signed [mjtp_pkg::POS_W-1:0]   end_position;
   modport source(output valid, mode, joint_index, start_position, end_position,
                  input ready);
   modport sink(input valid, mode, joint_index, start_position, end_position,
                output ready);
endinterface

interface mjtp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mjtp_pkg::JOINT_W-1:0]        joint_number;
   logic signed [mjtp_pkg::POS_W-1:0]   position_reference;
   logic signed [mjtp_pkg::POS_W-1:0]   velocity_reference;
   logic                                last;
   modport source(output valid, joint_number, position_reference, velocity_reference,
                  last, input ready);
   modport sink(input valid, joint_number, position_reference, velocity_reference,
                last, output ready);
endinterface

interface mjtp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mjtp_pkg::CSR_IDX_W-1:0]      index;
   logic [mjtp_pkg::CSR_DATA_W-1:0]     data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/multi_joint_trapezoid_profile_core.sv
// Multi-joint synchronised trapezoid profile.
// A tick transaction scans the joints in use to find the largest move, does the per-tick
// setup, then handles each joint in turn, mostly in the 34-step restoring dividers
// (position and velocity run side by side); each result waits for the response channel.
// Joints that hold or a profile at rest skip the dividers.
// Synchronous active-high reset: stores read as zero, counter 0, registers to defaults.
module multi_joint_trapezoid_profile_core #(
   parameter int MAX_JOINTS  = 8,
   parameter int ACCEL_TICKS = 2
) (
   input  logic             clock,
   input  logic             reset,
   mjtp_req_if.sink         req_if,
   mjtp_rsp_if.source       rsp_if,
   mjtp_csr_if.sink         csr_if
);

   localparam int AW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int NMAX = (MAX_JOINTS < 8) ? MAX_JOINTS : 8;
   localparam int PW   = mjtp_pkg::POS_W;

   typedef enum logic [14:0] {
      ST_IDLE       = 15'b000000000000001,
      ST_SCAN_RD    = 15'b000000000000010,
      ST_SCAN_CMP   = 15'b000000000000100,
      ST_PREP_MUL   = 15'b000000000001000,
      ST_PREP_PHASE = 15'b000000000010000,
      ST_PREP_MUL2  = 15'b000000000100000,
      ST_PREP_SEL   = 15'b000000001000000,
      ST_J_RD       = 15'b000000010000000,
      ST_J_LD       = 15'b000000100000000,
      ST_J_M1       = 15'b000001000000000,
      ST_J_M2       = 15'b000010000000000,
      ST_J_M3       = 15'b000100000000000,
      ST_J_DIV      = 15'b001000000000000,
      ST_J_FIN      = 15'b010000000000000,
      ST_J_OUT      = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [mjtp_pkg::PEAK_W-1:0]  peak_ff;
   logic [mjtp_pkg::COUNT_W-1:0] count_ff;
   logic [mjtp_pkg::PEAK_W-1:0]  v_eff;
   logic [2:0]                   n_last;

   // joint store: {start, target}, one entry per joint
   logic [2*PW-1:0]         mem [MAX_JOINTS];
   logic [MAX_JOINTS-1:0]   valid_ff;
   logic [2*PW-1:0]         rd_data_ff;
   logic                    rd_vld_ff;
   logic [AW-1:0]           rd_addr;
   logic [AW-1:0]           wr_addr;
   logic                    req_take;
   logic                    load_take;
   logic                    tick_take;
   logic                    load_in_range;

   logic [31:0]             elapsed_ff;
   logic [2:0]              idx_ff;
   logic [31:0]             dmax_ff;
   logic                    still;

   logic [PW-1:0]           eff_start;
   logic [PW-1:0]           eff_target;
   logic [PW:0]             diff_c;
   logic [PW-1:0]           dmag_c;

   // per-tick setup
   logic [mjtp_pkg::VT_W-1:0]  vt_ff;
   logic [19:0]                va_c;
   mjtp_pkg::phase_type        phase_ff, phase_in;
   logic [mjtp_pkg::R_W-1:0]   r_ff, r_in;
   logic [39:0]                rr_ff;
   logic [47:0]                dv_ff;
   logic [24:0]                vtt_ff;
   logic [mjtp_pkg::BS_W-1:0]  bs_ff, bs_in;
   logic [mjtp_pkg::BV_W-1:0]  bv_ff, bv_in;
   logic [mjtp_pkg::C_W-1:0]   cs_ff, cs_in;
   logic [mjtp_pkg::C_W-1:0]   cv_ff, cv_in;

   // per-joint datapath
   logic [PW-1:0]              d_ff;
   logic                       neg_ff;
   logic [PW-1:0]              jstart_ff;
   logic [PW-1:0]              jtarget_ff;
   logic [mjtp_pkg::PP_W-1:0]  plo_ff;
   logic [mjtp_pkg::PP_W-1:0]  phi_ff;
   logic [mjtp_pkg::PP_W-1:0]  prodv_ff;
   logic [mjtp_pkg::NUM_W-1:0] num_s;
   logic [mjtp_pkg::NUM_W-1:0] num_v;

   // dividers: remainder and dividend/quotient shift register
   logic [mjtp_pkg::C_W-1:0]   rs_ff, rv_ff, rs_in, rv_in;
   logic [mjtp_pkg::Q_W-1:0]   shs_ff, shv_ff, shs_in, shv_in;
   logic [mjtp_pkg::C_W:0]     rs_try, rv_try;
   logic                       s_ge, v_ge;
   logic [5:0]                 cnt_ff;

   logic signed [34:0]         s_c;
   logic signed [34:0]         sd_c;
   logic signed [35:0]         pos_c;
   logic signed [35:0]         vel_c;
   logic [PW-1:0]              pos_ff;
   logic [PW-1:0]              vel_ff;

   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_num_ff;
   logic [PW-1:0]              rsp_pos_ff;
   logic [PW-1:0]              rsp_vel_ff;
   logic                       rsp_last_ff;
   logic                       out_free;

   // ---------------- configuration ----------------
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= mjtp_pkg::PEAK_VELOCITY_RST;
         count_ff <= mjtp_pkg::JOINTS_IN_USE_RST;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            mjtp_pkg::REG_PEAK_VELOCITY: peak_ff  <= csr_if.data;
            mjtp_pkg::REG_JOINTS_IN_USE: count_ff <= csr_if.data[mjtp_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign v_eff = (peak_ff == '0) ? 16'd1 : peak_ff;

   always_comb begin
      if (count_ff == '0) begin
         n_last = 3'd0;
      end else if (32'(count_ff) > NMAX) begin
         n_last = 3'(NMAX - 1);
      end else begin
         n_last = 3'(count_ff - 4'd1);
      end
   end

   // ---------------- joint store ----------------
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_take      = req_if.valid && req_if.ready;
   assign load_take     = req_take && req_if.mode;
   assign tick_take     = req_take && !req_if.mode;
   assign load_in_range = 32'(req_if.joint_index) < MAX_JOINTS;
   assign wr_addr       = AW'(req_if.joint_index);
   assign rd_addr       = AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (load_take && load_in_range) begin
         mem[wr_addr] <= {req_if.start_position, req_if.end_position};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (load_take && load_in_range) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // an entry never loaded reads as zero
   assign eff_start  = rd_vld_ff ? rd_data_ff[2*PW-1:PW] : '0;
   assign eff_target = rd_vld_ff ? rd_data_ff[PW-1:0]    : '0;
   assign diff_c     = {eff_target[PW-1], eff_target} - {eff_start[PW-1], eff_start};
   assign dmag_c     = diff_c[PW] ? PW'(33'd0 - diff_c) : diff_c[PW-1:0];
   assign still      = (dmax_ff == '0);

   // ---------------- per-tick setup ----------------
   assign va_c = 20'(v_eff) * 20'(ACCEL_TICKS);

   always_comb begin
      if (elapsed_ff < 32'(ACCEL_TICKS)) begin
         phase_in = mjtp_pkg::PH_ACCEL;
      end else if (vt_ff < 48'(dmax_ff)) begin
         phase_in = mjtp_pkg::PH_CRUISE;
      end else if (vt_ff < 48'(dmax_ff) + 48'(va_c)) begin
         phase_in = mjtp_pkg::PH_DECEL;
      end else begin
         phase_in = mjtp_pkg::PH_HOLD;
      end
      // only meaningful while decelerating, where it stays within V*A
      r_in = mjtp_pkg::R_W'(48'(dmax_ff) + 48'(va_c) - vt_ff);
   end

   always_comb begin
      case (phase_ff)
         mjtp_pkg::PH_ACCEL: begin
            bs_in = mjtp_pkg::BS_W'(vtt_ff);
            cs_in = 53'(dmax_ff) * 53'(2 * ACCEL_TICKS);
            bv_in = vt_ff[mjtp_pkg::BV_W-1:0];
            cv_in = 53'(dmax_ff) * 53'(ACCEL_TICKS);
         end
         mjtp_pkg::PH_CRUISE: begin
            bs_in = mjtp_pkg::BS_W'({vt_ff, 1'b0} - 49'(va_c));
            cs_in = 53'({dmax_ff, 1'b0});
            bv_in = 20'(v_eff);
            cv_in = 53'(dmax_ff);
         end
         mjtp_pkg::PH_DECEL: begin
            bs_in = rr_ff;
            cs_in = 53'(dv_ff) * 53'(2 * ACCEL_TICKS);
            bv_in = r_ff;
            cv_in = 53'(dmax_ff) * 53'(ACCEL_TICKS);
         end
         default: begin
            bs_in = '0;
            cs_in = 53'd1;
            bv_in = '0;
            cv_in = 53'd1;
         end
      endcase
   end

   // ---------------- dividers ----------------
   assign num_s = 73'({phi_ff, 20'b0}) + 73'(plo_ff) + 73'(cs_ff[mjtp_pkg::C_W-1:1]);
   assign num_v = 73'(prodv_ff) + 73'(cv_ff[mjtp_pkg::C_W-1:1]);

   always_comb begin
      rs_try = {rs_ff, shs_ff[mjtp_pkg::Q_W-1]};
      rv_try = {rv_ff, shv_ff[mjtp_pkg::Q_W-1]};
      s_ge   = rs_try >= {1'b0, cs_ff};
      v_ge   = rv_try >= {1'b0, cv_ff};
      rs_in  = s_ge ? mjtp_pkg::C_W'(rs_try - {1'b0, cs_ff}) : rs_try[mjtp_pkg::C_W-1:0];
      rv_in  = v_ge ? mjtp_pkg::C_W'(rv_try - {1'b0, cv_ff}) : rv_try[mjtp_pkg::C_W-1:0];
      shs_in = {shs_ff[mjtp_pkg::Q_W-2:0], s_ge};
      shv_in = {shv_ff[mjtp_pkg::Q_W-2:0], v_ge};
   end

   // ---------------- result forming ----------------
   always_comb begin
      case (phase_ff)
         mjtp_pkg::PH_HOLD: begin
            s_c  = $signed({3'b0, d_ff});
            sd_c = '0;
         end
         mjtp_pkg::PH_DECEL: begin
            s_c  = $signed({3'b0, d_ff}) - $signed({1'b0, shs_ff});
            sd_c = $signed({1'b0, shv_ff});
         end
         default: begin
            s_c  = $signed({1'b0, shs_ff});
            sd_c = $signed({1'b0, shv_ff});
         end
      endcase
      if (neg_ff) begin
         pos_c = $signed({{4{jstart_ff[PW-1]}}, jstart_ff}) - 36'(s_c);
         vel_c = -36'(sd_c);
      end else begin
         pos_c = $signed({{4{jstart_ff[PW-1]}}, jstart_ff}) + 36'(s_c);
         vel_c = 36'(sd_c);
      end
   end

   // ---------------- sequencer ----------------
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (tick_take) state_in = ST_SCAN_RD;
         ST_SCAN_RD:    state_in = ST_SCAN_CMP;
         ST_SCAN_CMP:   state_in = (idx_ff == n_last) ? ST_PREP_MUL : ST_SCAN_RD;
         ST_PREP_MUL:   state_in = ST_PREP_PHASE;
         ST_PREP_PHASE: state_in = ST_PREP_MUL2;
         ST_PREP_MUL2:  state_in = ST_PREP_SEL;
         ST_PREP_SEL:   state_in = ST_J_RD;
         ST_J_RD:       state_in = ST_J_LD;
         ST_J_LD:       state_in = ST_J_M1;
         ST_J_M1:       state_in = ST_J_M2;
         ST_J_M2:       state_in = ST_J_M3;
         ST_J_M3: begin
            state_in = (still || phase_ff == mjtp_pkg::PH_HOLD) ? ST_J_FIN : ST_J_DIV;
         end
         ST_J_DIV: begin
            if (cnt_ff == 6'(mjtp_pkg::Q_W - 1)) state_in = ST_J_FIN;
         end
         ST_J_FIN:      state_in = ST_J_OUT;
         ST_J_OUT: begin
            if (out_free) state_in = (idx_ff == n_last) ? ST_IDLE : ST_J_RD;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         elapsed_ff <= '0;
         idx_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (load_take) begin
            elapsed_ff <= '0;
         end else if (tick_take && elapsed_ff != 32'hffff_ffff) begin
            elapsed_ff <= elapsed_ff + 32'd1;
         end
         case (state_ff)
            ST_IDLE:     idx_ff <= '0;
            ST_SCAN_CMP: idx_ff <= (idx_ff == n_last) ? 3'd0 : idx_ff + 3'd1;
            ST_J_OUT:    if (out_free) idx_ff <= idx_ff + 3'd1;
            default: ;
         endcase
         cnt_ff <= (state_ff == ST_J_DIV) ? cnt_ff + 6'd1 : '0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE:       dmax_ff <= '0;
         ST_SCAN_CMP:   if (dmag_c > dmax_ff) dmax_ff <= dmag_c;
         ST_PREP_MUL:   vt_ff <= 48'(v_eff) * 48'(elapsed_ff);
         ST_PREP_PHASE: begin
            phase_ff <= phase_in;
            r_ff     <= r_in;
         end
         ST_PREP_MUL2: begin
            rr_ff  <= 40'(r_ff) * 40'(r_ff);
            dv_ff  <= 48'(dmax_ff) * 48'(v_eff);
            vtt_ff <= 25'(vt_ff[19:0]) * 25'(elapsed_ff[4:0]);
         end
         ST_PREP_SEL: begin
            bs_ff <= bs_in;
            bv_ff <= bv_in;
            cs_ff <= cs_in;
            cv_ff <= cv_in;
         end
         ST_J_LD: begin
            d_ff       <= dmag_c;
            neg_ff     <= diff_c[PW];
            jstart_ff  <= eff_start;
            jtarget_ff <= eff_target;
         end
         ST_J_M1: begin
            plo_ff   <= 52'(d_ff) * 52'(bs_ff[19:0]);
            prodv_ff <= 52'(d_ff) * 52'(bv_ff);
         end
         ST_J_M2:       phi_ff <= 52'(d_ff) * 52'(bs_ff[39:20]);
         ST_J_M3: begin
            // quotients stay below 2^34, so the top part is already below the divisor
            rs_ff  <= mjtp_pkg::C_W'(num_s[mjtp_pkg::NUM_W-1:mjtp_pkg::Q_W]);
            rv_ff  <= mjtp_pkg::C_W'(num_v[mjtp_pkg::NUM_W-1:mjtp_pkg::Q_W]);
            shs_ff <= num_s[mjtp_pkg::Q_W-1:0];
            shv_ff <= num_v[mjtp_pkg::Q_W-1:0];
         end
         ST_J_DIV: begin
            rs_ff  <= rs_in;
            rv_ff  <= rv_in;
            shs_ff <= shs_in;
            shv_ff <= shv_in;
         end
         ST_J_FIN: begin
            if (still) begin
               pos_ff <= jtarget_ff;
               vel_ff <= '0;
            end else begin
               pos_ff <= mjtp_pkg::sat32(pos_c);
               vel_ff <= mjtp_pkg::sat32(vel_c);
            end
         end
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_J_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_J_OUT && out_free) begin
         rsp_num_ff  <= idx_ff;
         rsp_pos_ff  <= pos_ff;
         rsp_vel_ff  <= vel_ff;
         rsp_last_ff <= (idx_ff == n_last);
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.joint_number       = rsp_num_ff;
   assign rsp_if.position_reference = rsp_pos_ff;
   assign rsp_if.velocity_reference = rsp_vel_ff;
   assign rsp_if.last               = rsp_last_ff;

   // ---------------- assertions ----------------
   a_load_clears_counter : assert property (@(posedge clock) disable iff (reset)
      load_take |=> elapsed_ff == '0)
      else $error("load transaction did not clear the tick counter");

   a_tick_advances : assert property (@(posedge clock) disable iff (reset)
      tick_take |=> elapsed_ff != '0)
      else $error("tick transaction left the counter at zero");

   a_div_remainder : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_J_DIV |-> (rs_ff < cs_ff) && (rv_ff < cv_ff))
      else $error("divider remainder not below divisor");

   a_last_joint : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.last |-> rsp_if.joint_number == n_last)
      else $error("last mark on wrong joint");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_J_OUT))
      else $error("result raised outside the output step");

endmodule
